>>> rtl/triangle_pixel_shader_core_assert.svh
// Assertion macros shared by the shader core.
`ifndef TRIANGLE_PIXEL_SHADER_CORE_ASSERT_SVH
`define TRIANGLE_PIXEL_SHADER_CORE_ASSERT_SVH

// same-cycle implication
`define TPS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("shader core check failed");

// next-cycle implication
`define TPS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("shader core check failed");

`endif

>>> rtl/tps_pkg.sv
`default_nettype none
package tps_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int SIDE_W     = 13;
    localparam int PIX_W      = 12;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TRIG_W     = 16;
    localparam int ROT_W      = 33;   // rotated vertex, Q.30
    localparam int SCALE_W    = 45;   // Q.30 times side
    localparam int FRAC_SHIFT = 23;
    localparam int COORD_W    = 22;   // Q.8 pixel coordinate, signed
    localparam int PROD_W     = 44;
    localparam int EDGE_W     = 45;
    localparam int MAG_W      = 44;
    localparam int WT_W       = 17;   // Q.16 weight
    localparam int DIV_STEPS  = 17;
    localparam int ACC_W      = 35;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;

    localparam logic [SIDE_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [SIDE_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [TRIG_W-1:0] RST_COS    = 16'h7FFF;
    localparam logic [TRIG_W-1:0] RST_SIN    = 16'h0000;

    localparam logic [31:0]   BG_ARGB = 32'hFF14141F;
    localparam logic [WT_W-1:0] C_ONE = 17'd65536;
    localparam logic [WT_W-1:0] C_LOW = 17'd13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ROT_COS      = 2'd2,
        REG_ROT_SIN      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix_x;
        logic [PIX_W-1:0] pix_y;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] argb;
        logic        covered;
    } pix_out_t;

    // triangle set up from the registers
    typedef struct packed {
        logic [2:0][COORD_W-1:0] vx;
        logic [2:0][COORD_W-1:0] vy;
        logic [MAG_W-1:0]        area_mag;
        logic                    area_neg;
        logic                    degen;
        logic [SIDE_W-1:0]       width;
        logic [SIDE_W-1:0]       height;
        logic                    ready;
    } geom_t;

    typedef struct packed {
        logic                  covered;
        logic [2:0][MAG_W-1:0] mag;
    } edge_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // unit triangle, Q.15
    function automatic logic signed [TRIG_W-1:0] vtx_x(input logic [1:0] i);
        logic signed [TRIG_W-1:0] v;
        unique case (i)
            2'd0:    v = 16'sd0;
            2'd1:    v = -16'sd19661;
            2'd2:    v = 16'sd19661;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TRIG_W-1:0] vtx_y(input logic [1:0] i);
        logic signed [TRIG_W-1:0] v;
        unique case (i)
            2'd0:    v = 16'sd19661;
            2'd1:    v = -16'sd13107;
            2'd2:    v = -16'sd13107;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/triangle_pixel_shader_core.sv
// Triangle pixel shader core: one ARGB colour per pixel coordinate.
// Input channel in_valid/in_ready/in_data carries (pix_x, pix_y); output channel
// out_valid/out_ready/out_data carries (argb, covered). Each accepted item gives
// exactly one result, in order.
// Throughput: one item per clock while in_ready stays high. With no stall an item
// passes 3 front stages (edge products), one queue slot, 17 divider stages
// (one quotient bit each), colour accumulate and the output register.
// Configuration: cfg_we/cfg_index/cfg_data writes a register. Any write, and
// reset, starts a setup pass that rotates and maps the three vertices and
// computes the signed area; in_ready stays low until it is done. Reset loads
// 640x480, cos 32767, sin 0.
// Stalls: while out_valid waits on out_ready the back pipeline holds; the 4-entry
// queue absorbs front items, and in_ready drops once it is full and stage 3 holds one.
`default_nettype none
`include "triangle_pixel_shader_core_assert.svh"
module triangle_pixel_shader_core
    import tps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pix_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pix_out_t                  out_data
);

    geom_t      geom;
    edge_item_t push_item, head_item;
    fifo_stat_t fifo_stat;
    logic       push, pop;

    // triangle setup from the registers
    tps_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // edge functions and coverage
    tps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .fifo_full (fifo_stat.full),
        .push      (push),
        .item      (push_item)
    );

    tps_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (head_item),
        .stat    (fifo_stat)
    );

    // weights and colour blend
    tps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .area_mag   (geom.area_mag),
        .head       (head_item),
        .fifo_empty (fifo_stat.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // a register write restarts setup, so no item enters on the next edge
    `TPS_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_we, !in_ready)
    // the queue never takes an item while full
    `TPS_ASSERT_NOW(a_no_push_when_full, clk, rst_n, fifo_stat.full, !push)
    // an uncovered pixel is always background
    `TPS_ASSERT_NOW(a_bg_when_uncovered, clk, rst_n, out_valid && !out_data.covered, out_data.argb == BG_ARGB)

endmodule
`default_nettype wire

>>> rtl/tps_setup.sv
`default_nettype none
module tps_setup
    import tps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output geom_t                     geom
);

    typedef enum logic [5:0] {
        SU_ROT   = 6'b000001,
        SU_SCALE = 6'b000010,
        SU_STORE = 6'b000100,
        SU_AREA  = 6'b001000,
        SU_FIN   = 6'b010000,
        SU_DONE  = 6'b100000
    } setup_state_t;

    localparam logic signed [ROT_W-1:0] ONE_Q30 = 33'sh0_4000_0000;

    setup_state_t              state_reg;
    logic [1:0]                vidx_reg;
    logic [SIDE_W-1:0]         width_reg, height_reg;
    logic signed [TRIG_W-1:0]  cos_reg, sin_reg;
    logic signed [ROT_W-1:0]   rx_reg, ry_reg, rx_next, ry_next;
    logic [SCALE_W-1:0]        sx_reg, sy_reg, sx_next, sy_next;
    logic [2:0][COORD_W-1:0]   vx_reg, vy_reg;
    logic signed [PROD_W-1:0]  ap_reg, an_reg, ap_next, an_next;
    logic [MAG_W-1:0]          area_mag_reg;
    logic                      area_neg_reg, degen_reg;

    logic [SIDE_W-1:0]         w_eff, h_eff;
    logic signed [31:0]        p_xc, p_ys, p_xs, p_yc;
    logic signed [ROT_W-1:0]   bx, by;
    logic signed [COORD_W-1:0] dx1, dy1, dx2, dy2;
    logic signed [EDGE_W-1:0]  area;

    assign w_eff = (width_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_reg;
    assign h_eff = (height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_reg;

    always_comb
    begin
        p_xc = vtx_x(vidx_reg) * cos_reg;
        p_ys = vtx_y(vidx_reg) * sin_reg;
        p_xs = vtx_x(vidx_reg) * sin_reg;
        p_yc = vtx_y(vidx_reg) * cos_reg;
        rx_next = {p_xc[31], p_xc} - {p_ys[31], p_ys};
        ry_next = {p_xs[31], p_xs} + {p_yc[31], p_yc};
        // both land in [0, 2^31]
        bx = rx_reg + ONE_Q30;
        by = ONE_Q30 - ry_reg;
        sx_next = SCALE_W'(bx[31:0]) * SCALE_W'(w_eff);
        sy_next = SCALE_W'(by[31:0]) * SCALE_W'(h_eff);
        dx1 = $signed(vx_reg[1]) - $signed(vx_reg[0]);
        dy1 = $signed(vy_reg[1]) - $signed(vy_reg[0]);
        dx2 = $signed(vx_reg[2]) - $signed(vx_reg[0]);
        dy2 = $signed(vy_reg[2]) - $signed(vy_reg[0]);
        ap_next = dx1 * dy2;
        an_next = dy1 * dx2;
        area = {ap_reg[PROD_W-1], ap_reg} - {an_reg[PROD_W-1], an_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SU_ROT;
            vidx_reg   <= 2'd0;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            cos_reg    <= RST_COS;
            sin_reg    <= RST_SIN;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[SIDE_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[SIDE_W-1:0];
                REG_ROT_COS:      cos_reg    <= cfg_data[TRIG_W-1:0];
                REG_ROT_SIN:      sin_reg    <= cfg_data[TRIG_W-1:0];
                default:          ;
            endcase
            state_reg <= SU_ROT;
            vidx_reg  <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                SU_ROT:   state_reg <= SU_SCALE;
                SU_SCALE: state_reg <= SU_STORE;
                SU_STORE:
                begin
                    if (vidx_reg == 2'd2)
                    begin
                        state_reg <= SU_AREA;
                    end
                    else
                    begin
                        vidx_reg  <= vidx_reg + 2'd1;
                        state_reg <= SU_ROT;
                    end
                end
                SU_AREA:  state_reg <= SU_FIN;
                SU_FIN:   state_reg <= SU_DONE;
                SU_DONE:  state_reg <= SU_DONE;
                default:  state_reg <= SU_ROT;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        ap_reg <= ap_next;
        an_reg <= an_next;
        if (state_reg == SU_STORE)
        begin
            vx_reg[vidx_reg] <= sx_reg[FRAC_SHIFT +: COORD_W];
            vy_reg[vidx_reg] <= sy_reg[FRAC_SHIFT +: COORD_W];
        end
        if (state_reg == SU_FIN)
        begin
            area_neg_reg <= area[EDGE_W-1];
            degen_reg    <= (area == '0);
            area_mag_reg <= area[EDGE_W-1] ? MAG_W'(-area) : MAG_W'(area);
        end
    end

    always_comb
    begin
        geom.vx       = vx_reg;
        geom.vy       = vy_reg;
        geom.area_mag = area_mag_reg;
        geom.area_neg = area_neg_reg;
        geom.degen    = degen_reg;
        geom.width    = w_eff;
        geom.height   = h_eff;
        geom.ready    = (state_reg == SU_DONE);
    end

endmodule
`default_nettype wire

>>> rtl/tps_front.sv
`default_nettype none
module tps_front
    import tps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire geom_t geom,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire pix_in_t in_data,
    input  wire logic  fifo_full,
    output logic       push,
    output edge_item_t item
);

    logic                      en;
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [COORD_W-1:0] s1_fx_reg, s1_fy_reg;
    logic                      s1_in_reg, s2_in_reg;
    logic signed [PROD_W-1:0]  pa_reg [3];
    logic signed [PROD_W-1:0]  pb_reg [3];
    logic signed [PROD_W-1:0]  pa_next [3];
    logic signed [PROD_W-1:0]  pb_next [3];
    logic signed [COORD_W-1:0] dx [3];
    logic signed [COORD_W-1:0] dy [3];
    logic signed [COORD_W-1:0] qx [3];
    logic signed [COORD_W-1:0] qy [3];
    logic signed [EDGE_W-1:0]  e [3];
    logic [2:0]                bad;
    edge_item_t                item_reg, item_next;

    assign en       = !(s3_valid_reg && fifo_full);
    assign in_ready = en && geom.ready;
    assign push     = s3_valid_reg && !fifo_full;
    assign item     = item_reg;

    // edge k runs from vertex k+1 to vertex k+2
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dx[k] = $signed(geom.vx[(k + 2) % 3]) - $signed(geom.vx[(k + 1) % 3]);
            dy[k] = $signed(geom.vy[(k + 2) % 3]) - $signed(geom.vy[(k + 1) % 3]);
            qx[k] = s1_fx_reg - $signed(geom.vx[(k + 1) % 3]);
            qy[k] = s1_fy_reg - $signed(geom.vy[(k + 1) % 3]);
            pa_next[k] = dx[k] * qy[k];
            pb_next[k] = dy[k] * qx[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            e[k] = {pa_reg[k][PROD_W-1], pa_reg[k]} - {pb_reg[k][PROD_W-1], pb_reg[k]};
            // zero counts as inside on either winding
            bad[k] = geom.area_neg ? (!e[k][EDGE_W-1] && (e[k] != '0)) : e[k][EDGE_W-1];
            item_next.mag[k] = e[k][EDGE_W-1] ? MAG_W'(-e[k]) : MAG_W'(e[k]);
        end
        item_next.covered = s2_in_reg && !geom.degen && (bad == 3'b000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid && in_ready;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_fx_reg <= {2'b00, in_data.pix_x, 8'h80};
            s1_fy_reg <= {2'b00, in_data.pix_y, 8'h80};
            s1_in_reg <= ({1'b0, in_data.pix_x} < geom.width) &&
                         ({1'b0, in_data.pix_y} < geom.height);
            s2_in_reg <= s1_in_reg;
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= pa_next[k];
                pb_reg[k] <= pb_next[k];
            end
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tps_fifo.sv
`default_nettype none
module tps_fifo
    import tps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire edge_item_t wr_item,
    input  wire logic  pop,
    output edge_item_t rd_item,
    output fifo_stat_t stat
);

    edge_item_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign rd_item    = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PTR_W + 1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tps_back.sv
`default_nettype none
module tps_back
    import tps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [MAG_W-1:0] area_mag,
    input  wire edge_item_t       head,
    input  wire logic             fifo_empty,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pix_out_t              out_data
);

    logic                en;
    logic [MAG_W-1:0]    r_reg  [DIV_STEPS][3];
    logic [WT_W-1:0]     q_reg  [DIV_STEPS][3];
    logic [MAG_W-1:0]    r_next [DIV_STEPS][3];
    logic [WT_W-1:0]     q_next [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] dv_reg, dc_reg;
    logic [MAG_W:0]      sh;
    logic                ge;
    logic [2:0][ACC_W-1:0] acc_reg, acc_next;
    logic                c1_valid_reg, c1_cov_reg;
    logic [ACC_W+7:0]    scaled [3];
    logic [7:0]          chan [3];
    logic                out_valid_reg;
    pix_out_t            out_reg;

    assign en        = !(out_valid_reg && !out_ready);
    assign pop       = en && !fifo_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // restoring division, one quotient bit per stage; |e| <= |area|
    always_comb
    begin
        sh = '0;
        ge = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ge = (head.mag[k] >= area_mag);
            r_next[0][k] = ge ? head.mag[k] - area_mag : head.mag[k];
            q_next[0][k] = {{(WT_W - 1){1'b0}}, ge};
        end
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sh = {r_reg[j-1][k], 1'b0};
                ge = (sh >= {1'b0, area_mag});
                r_next[j][k] = ge ? MAG_W'(sh - {1'b0, area_mag}) : MAG_W'(sh);
                q_next[j][k] = {q_reg[j-1][k][WT_W-2:0], ge};
            end
        end
        acc_next[0] = ACC_W'(q_reg[DIV_STEPS-1][0]) * ACC_W'(C_ONE) +
                      ACC_W'(q_reg[DIV_STEPS-1][1]) * ACC_W'(C_LOW) +
                      ACC_W'(q_reg[DIV_STEPS-1][2]) * ACC_W'(C_LOW);
        acc_next[1] = ACC_W'(q_reg[DIV_STEPS-1][0]) * ACC_W'(C_LOW) +
                      ACC_W'(q_reg[DIV_STEPS-1][1]) * ACC_W'(C_ONE) +
                      ACC_W'(q_reg[DIV_STEPS-1][2]) * ACC_W'(C_LOW);
        acc_next[2] = ACC_W'(q_reg[DIV_STEPS-1][0]) * ACC_W'(C_LOW) +
                      ACC_W'(q_reg[DIV_STEPS-1][1]) * ACC_W'(C_LOW) +
                      ACC_W'(q_reg[DIV_STEPS-1][2]) * ACC_W'(C_ONE);
        // times 255, drop 32 bits, clamp
        for (int k = 0; k < 3; k++)
        begin
            scaled[k] = {acc_reg[k], 8'h00} - (ACC_W + 8)'(acc_reg[k]);
            chan[k] = (scaled[k][ACC_W+7:32] > 11'd255) ? 8'hFF : scaled[k][39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg        <= '0;
            c1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg        <= {dv_reg[DIV_STEPS-2:0], !fifo_empty};
            c1_valid_reg  <= dv_reg[DIV_STEPS-1];
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_reg     <= {dc_reg[DIV_STEPS-2:0], head.covered};
            c1_cov_reg <= dc_reg[DIV_STEPS-1];
            acc_reg    <= acc_next;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    r_reg[j][k] <= r_next[j][k];
                    q_reg[j][k] <= q_next[j][k];
                end
            end
            out_reg.covered <= c1_cov_reg;
            out_reg.argb    <= c1_cov_reg ? {8'hFF, chan[0], chan[1], chan[2]} : BG_ARGB;
        end
    end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import tps_pkg::*;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    // DUT-facing signals; every input to the DUT starts at a known value
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    pix_in_t              in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    pix_out_t             out_data;

    triangle_pixel_shader_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the configuration registers
    logic [SIDE_W-1:0] shd_width  = RST_WIDTH;
    logic [SIDE_W-1:0] shd_height = RST_HEIGHT;
    logic [TRIG_W-1:0] shd_cos    = RST_COS;
    logic [TRIG_W-1:0] shd_sin    = RST_SIN;

    pix_in_t  pixel_queue[$];      // items waiting to be driven
    pix_out_t colour_queue[$];     // predicted colours, oldest first
    int       err_count = 0;
    bit       drv_hold = 1'b0;     // sender pause requested by the stimulus
    bit       no_idle = 1'b0;      // stretch with no random idling
    int       sink_hold = 0;       // cycles the receiver keeps holding off

    // floor(v / 2^23) for a signed value
    function automatic longint floor_q23(input longint v);
        return v >>> 23;
    endfunction

    function automatic longint edge_val(input longint x1, input longint y1,
                                        input longint x2, input longint y2,
                                        input longint qx, input longint qy);
        return (x2 - x1) * (qy - y1) - (y2 - y1) * (qx - x1);
    endfunction

    // Q.16 weight: floor(num * 2^16 / den), exact
    function automatic longint weight_q16(input longint num, input longint den);
        return (num <<< 16) / den;
    endfunction

    function automatic longint blend_chan(input longint c0, input longint c1,
                                          input longint c2, input longint w0,
                                          input longint w1, input longint w2);
        logic [63:0] acc;
        logic [63:0] v;
        acc = c0 * w0 + c1 * w1 + c2 * w2;
        v = (acc * 64'd255) >> 32;
        return (v > 255) ? 255 : v;
    endfunction

    // Expected shading of one pixel under the current shadow registers
    function automatic pix_out_t shade_pixel(input pix_in_t p);
        pix_out_t r;
        longint w, h, x, y, c, s, area, fx, fy, aa, rx, ry;
        longint vx[3], vy[3], e[3], wt[3];
        longint ux[3], uy[3];
        ux[0] = 0;      uy[0] = 19661;
        ux[1] = -19661; uy[1] = -13107;
        ux[2] = 19661;  uy[2] = -13107;
        r.argb = BG_ARGB;
        r.covered = 1'b0;
        w = (shd_width > MAX_SIDE) ? MAX_SIDE : shd_width;
        h = (shd_height > MAX_SIDE) ? MAX_SIDE : shd_height;
        x = p.pix_x;
        y = p.pix_y;
        c = longint'($signed(shd_cos));
        s = longint'($signed(shd_sin));
        if (x >= w || y >= h)
            return r;
        for (int i = 0; i < 3; i++)
        begin
            rx = ux[i] * c - uy[i] * s;
            ry = ux[i] * s + uy[i] * c;
            vx[i] = floor_q23((rx + (64'sd1 <<< 30)) * w);
            vy[i] = floor_q23(((64'sd1 <<< 30) - ry) * h);
        end
        area = edge_val(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
        if (area == 0)
            return r;
        fx = (x <<< 8) + 128;
        fy = (y <<< 8) + 128;
        e[0] = edge_val(vx[1], vy[1], vx[2], vy[2], fx, fy);
        e[1] = edge_val(vx[2], vy[2], vx[0], vy[0], fx, fy);
        e[2] = edge_val(vx[0], vy[0], vx[1], vy[1], fx, fy);
        for (int i = 0; i < 3; i++)
        begin
            if (area > 0 ? e[i] < 0 : e[i] > 0)
                return r;
        end
        aa = (area < 0) ? -area : area;
        for (int i = 0; i < 3; i++)
            wt[i] = weight_q16((e[i] < 0) ? -e[i] : e[i], aa);
        r.argb = {8'hFF,
                  8'(blend_chan(65536, 13107, 13107, wt[0], wt[1], wt[2])),
                  8'(blend_chan(13107, 65536, 13107, wt[0], wt[1], wt[2])),
                  8'(blend_chan(13107, 13107, 65536, wt[0], wt[1], wt[2]))};
        r.covered = 1'b1;
        return r;
    endfunction

    // Driver: offers the queue head; valid stays up until accepted
    always @(posedge clk)
    begin
        bit fire;
        bit idle;
        fire = in_valid && in_ready;
        if (fire)
        begin
            colour_queue.push_back(shade_pixel(in_data));
            void'(pixel_queue.pop_front());
        end
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !fire)
            ;   // hold the item until accepted
        else
        begin
            idle = !no_idle && ($urandom_range(0, 99) < 10);
            if (pixel_queue.size() > 0 && !drv_hold && !idle)
            begin
                in_valid <= 1'b1;
                in_data  <= pixel_queue[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (colour_queue.size() == 0)
            begin
                $error("unexpected result argb=%h covered=%0b",
                       out_data.argb, out_data.covered);
                err_count++;
            end
            else
            begin
                want = colour_queue.pop_front();
                if (out_data.argb !== want.argb)
                begin
                    $error("argb mismatch: expected %h actual %h", want.argb, out_data.argb);
                    err_count++;
                end
                if (out_data.covered !== want.covered)
                begin
                    $error("covered mismatch: expected %0b actual %0b",
                           want.covered, out_data.covered);
                    err_count++;
                end
            end
        end
        // receiver ready: long hold-off when asked, else random 10% stalls unless no_idle is set
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 10);
    end

    // Watchdog: cycles with no handshake on either channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || colour_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);   // covers pipeline latency
    endtask

    // Register write, only while idle
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  shd_width  = val[SIDE_W-1:0];
            REG_FRAME_HEIGHT: shd_height = val[SIDE_W-1:0];
            REG_ROT_COS:      shd_cos    = val;
            REG_ROT_SIN:      shd_sin    = val;
            default: ;
        endcase
        repeat (2) @(posedge clk);
    endtask

    function automatic pix_in_t mk_pix(input int x, input int y);
        pix_in_t p;
        p.pix_x = x[PIX_W-1:0];
        p.pix_y = y[PIX_W-1:0];
        return p;
    endfunction

    // Pixel mostly inside the frame, sometimes anywhere
    function automatic pix_in_t rand_pix();
        int wl, hl;
        wl = (shd_width > MAX_SIDE) ? MAX_SIDE : shd_width;
        hl = (shd_height > MAX_SIDE) ? MAX_SIDE : shd_height;
        if ($urandom_range(0, 9) == 0 || wl == 0 || hl == 0)
            return mk_pix($urandom_range(0, 4095), $urandom_range(0, 4095));
        return mk_pix($urandom_range(0, wl - 1), $urandom_range(0, hl - 1));
    endfunction

    initial
    begin
        int wcfg, hcfg;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // directed: reset setting, frame corners, center, outside frame
        pixel_queue.push_back(mk_pix(0, 0));
        pixel_queue.push_back(mk_pix(639, 479));
        pixel_queue.push_back(mk_pix(320, 240));
        pixel_queue.push_back(mk_pix(320, 100));
        pixel_queue.push_back(mk_pix(640, 0));
        pixel_queue.push_back(mk_pix(0, 480));
        pixel_queue.push_back(mk_pix(4095, 4095));
        wait_drained();

        // oversized frame clamps to the maximum side
        write_reg(REG_FRAME_WIDTH, 16'd8191);
        write_reg(REG_FRAME_HEIGHT, 16'd4097);
        pixel_queue.push_back(mk_pix(2048, 2048));
        pixel_queue.push_back(mk_pix(4095, 4095));
        pixel_queue.push_back(mk_pix(2048, 800));
        wait_drained();

        // zero-size frame: everything is outside
        write_reg(REG_FRAME_WIDTH, 16'd0);
        pixel_queue.push_back(mk_pix(0, 0));
        wait_drained();

        // degenerate triangle: zero rotation collapses it
        write_reg(REG_FRAME_WIDTH, 16'd64);
        write_reg(REG_FRAME_HEIGHT, 16'd64);
        write_reg(REG_ROT_COS, 16'h0000);
        write_reg(REG_ROT_SIN, 16'h0000);
        pixel_queue.push_back(mk_pix(32, 32));
        pixel_queue.push_back(mk_pix(0, 0));
        wait_drained();

        // extreme, unnormalised rotation values
        write_reg(REG_ROT_COS, 16'h8000);
        write_reg(REG_ROT_SIN, 16'h7FFF);
        pixel_queue.push_back(mk_pix(32, 32));
        pixel_queue.push_back(mk_pix(63, 63));
        pixel_queue.push_back(mk_pix(1, 1));
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 16'd1);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        pixel_queue.push_back(mk_pix(0, 0));
        pixel_queue.push_back(mk_pix(1, 0));
        wait_drained();

        // random phases, each with its own setting
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: wcfg = $urandom_range(1, 64);
                1: wcfg = $urandom_range(1, 8191);
                2: wcfg = $urandom_range(100, 700);
                default: wcfg = 4096;
            endcase
            hcfg = (ph == 5) ? 8191 : $urandom_range(1, (ph % 4 == 1) ? 8191 : 600);
            write_reg(REG_FRAME_WIDTH, 16'(wcfg));
            write_reg(REG_FRAME_HEIGHT, 16'(hcfg));
            write_reg(REG_ROT_COS, (ph == 0) ? 16'h7FFF : 16'($urandom_range(0, 65535)));
            write_reg(REG_ROT_SIN, (ph == 1) ? 16'h8000 : 16'($urandom_range(0, 65535)));
            no_idle = (ph == 3);
            if (ph == 6)
                sink_hold = 300;   // receiver stalls; input must back up
            for (int i = 0; i < 70; i++)
                pixel_queue.push_back(rand_pix());
            if (ph == 8)
            begin
                // sender pauses until every result has come
                while (pixel_queue.size() > 35)
                    @(posedge clk);
                drv_hold = 1'b1;
                while (colour_queue.size() > 0 || in_valid)
                    @(posedge clk);
                drv_hold = 1'b0;
            end
            wait_drained();
            no_idle = 1'b0;
        end

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
